/* sv/alc_pkg.sv */
// ----------------------------------------------------------------------------
// alc_pkg
// Shared widths, codes and reset values for the light sensor auto-ranging
// controller and its lux correction unit.
// ----------------------------------------------------------------------------
package alc_pkg;

  // field widths
  localparam int CNT_W     = 16;
  localparam int LUX_IN_W  = 32;
  localparam int LUX_OUT_W = 34;
  localparam int GAIN_W    = 3;
  localparam int TIME_W    = 3;
  localparam int ACT_W     = 2;
  localparam int IDX_W     = 2;
  localparam int CFG_W     = 16;

  // default number of fraction bits of the lux values
  localparam int LUX_FRAC_BITS_DEF = 12;

  // correction datapath widths
  localparam int MUL_W    = 32;           // multiplier operand width
  localparam int PROD_W   = 2 * MUL_W;    // product width
  localparam int CHUNKS   = 3;            // operand chunks per multiply pass
  localparam int OPND_W   = CHUNKS * MUL_W;
  localparam int ACC_W    = 98;           // holds the full cubic numerator
  localparam int DIV_W    = 64;           // remainder width once in quotient range
  localparam int QUO_W    = LUX_OUT_W;    // quotient bits produced

  // result action codes
  localparam logic [ACT_W-1:0] ACT_MEASURE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_RAW     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CORR    = 2'd2;

  // input kind codes
  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_START_GAIN = 2'd0;
  localparam logic [IDX_W-1:0] REG_START_TIME = 2'd1;
  localparam logic [IDX_W-1:0] REG_LOW_LIMIT  = 2'd2;
  localparam logic [IDX_W-1:0] REG_HIGH_LIMIT = 2'd3;

  // register reset values
  localparam logic [GAIN_W-1:0] START_GAIN_RST = 3'd1;
  localparam logic [TIME_W-1:0] START_TIME_RST = 3'd0;
  localparam logic [CNT_W-1:0]  LOW_LIMIT_RST  = 16'd100;
  localparam logic [CNT_W-1:0]  HIGH_LIMIT_RST = 16'd10000;

  // gain and integration step limits
  localparam logic [GAIN_W-1:0]        GAIN_MIN = 3'd1;
  localparam logic [GAIN_W-1:0]        GAIN_MAX = 3'd4;
  localparam logic signed [TIME_W-1:0] TIME_MIN = -3'sd2;
  localparam logic signed [TIME_W-1:0] TIME_MAX = 3'sd3;

  localparam logic [LUX_OUT_W-1:0] LUX_MAX = {LUX_OUT_W{1'b1}};

endpackage

/* sv/alc_corr.sv */
// ----------------------------------------------------------------------------
// alc_corr
// Iterative lux correction: evaluates the cubic through a shared 32x32
// multiply-accumulate unit, then divides by 10^9 through the same unit with
// a reciprocal quotient estimate and a short remainder correction.
// ----------------------------------------------------------------------------
module alc_corr
  import alc_pkg::*;
#(
  parameter int LUX_FRAC_BITS = LUX_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [LUX_IN_W-1:0]  lux,
  output logic                 done,
  output logic [LUX_OUT_W-1:0] result
);

  // scaled coefficients of the cubic, numerator over 10^9 * 2^(2F)
  localparam logic [ACC_W-1:0] K_SQ   = ACC_W'(64'd3000) << LUX_FRAC_BITS;
  localparam logic [ACC_W-1:0] K_LIN  = ACC_W'(64'd1056400000) << (2 * LUX_FRAC_BITS);
  localparam logic [ACC_W-1:0] K_OFS  = ACC_W'(64'd30803000000) << (3 * LUX_FRAC_BITS);
  localparam logic [ACC_W-1:0] SAT_LIM = ACC_W'(64'd1000000000) << QUO_W;
  // divisor and floor(2^64 / 10^9) for the quotient estimate
  localparam logic [MUL_W-1:0]  DIVISOR = MUL_W'(64'd1000000000);
  localparam logic [OPND_W-1:0] RECIP   = OPND_W'(64'd18446744073);
  localparam int               K_BITS   = $clog2(CHUNKS);

  typedef enum logic [2:0] {
    C_IDLE,
    C_MUL,
    C_ACC,
    C_SUB,
    C_SAT,
    C_FIX,
    C_FIN
  } corr_state_t;

  // what the current multiply pass computes
  typedef enum logic [1:0] {
    P_INNER,
    P_OUTER,
    P_EST,
    P_REM
  } pass_t;

  corr_state_t          state;
  pass_t                pass;
  logic [LUX_IN_W-1:0]  lux_r;
  logic [MUL_W-1:0]     mcand;
  logic [OPND_W-1:0]    opnd;
  logic [K_BITS-1:0]    k;
  logic [PROD_W-1:0]    prod;
  logic [ACC_W-1:0]     acc;
  logic [DIV_W-1:0]     num;
  logic [QUO_W-1:0]     quo;

  logic [MUL_W-1:0]     chunk;
  logic [ACC_W-1:0]     acc_next;
  logic [ACC_W-1:0]     acc_diff;
  logic [LUX_IN_W:0]    lux_plus;
  logic [QUO_W-1:0]     lux_wide;

  // operand chunk and shifted accumulate
  always_comb begin
    chunk    = opnd[{k, 5'b0} +: MUL_W];
    acc_next = acc + (ACC_W'(prod) << {k, 5'b0});
    acc_diff = acc - K_OFS;
    lux_plus = {1'b0, lux} + K_SQ[LUX_IN_W:0];
    lux_wide = {{(LUX_OUT_W-LUX_IN_W){1'b0}}, lux_r};
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == C_FIN);
      unique case (state)
        C_IDLE: begin
          if (start) begin
            // first pass: L * (L + 3000*2^F) + 1056400000*2^2F
            lux_r <= lux;
            mcand <= lux;
            opnd  <= OPND_W'(lux_plus);
            acc   <= K_LIN;
            k     <= '0;
            pass  <= P_INNER;
            state <= C_MUL;
          end
        end
        C_MUL: begin
          prod  <= {{(PROD_W-MUL_W){1'b0}}, mcand} * {{(PROD_W-MUL_W){1'b0}}, chunk};
          state <= C_ACC;
        end
        C_ACC: begin
          if (k == K_BITS'(CHUNKS - 1)) begin
            k <= '0;
            unique case (pass)
              P_INNER: begin
                // second pass multiplies the first sum by L again
                opnd  <= acc_next[OPND_W-1:0];
                acc   <= '0;
                pass  <= P_OUTER;
                state <= C_MUL;
              end
              P_OUTER: begin
                acc   <= acc_next;
                state <= C_SUB;
              end
              P_EST: begin
                // quotient estimate, low by at most six
                quo   <= acc_next[MUL_W +: QUO_W];
                mcand <= DIVISOR;
                opnd  <= OPND_W'(acc_next[MUL_W +: QUO_W]);
                acc   <= '0;
                pass  <= P_REM;
                state <= C_MUL;
              end
              P_REM: begin
                // remainder left by the estimate
                num   <= num - acc_next[DIV_W-1:0];
                state <= C_FIX;
              end
            endcase
          end else begin
            acc   <= acc_next;
            k     <= k + 1'b1;
            state <= C_MUL;
          end
        end
        C_SUB: begin
          // non-positive numerator keeps the raw lux
          if (acc <= K_OFS) begin
            result <= lux_wide;
            state  <= C_FIN;
          end else begin
            acc   <= acc_diff >> (2 * LUX_FRAC_BITS);
            state <= C_SAT;
          end
        end
        C_SAT: begin
          if (acc >= SAT_LIM) begin
            result <= LUX_MAX;
            state  <= C_FIN;
          end else begin
            // upper word of the dividend times the reciprocal
            num   <= acc[DIV_W-1:0];
            mcand <= acc[DIV_W-1:MUL_W];
            opnd  <= RECIP;
            acc   <= '0;
            pass  <= P_EST;
            state <= C_MUL;
          end
        end
        C_FIX: begin
          // bring the estimate up to the floored quotient
          if (num >= DIV_W'(DIVISOR)) begin
            num <= num - DIV_W'(DIVISOR);
            quo <= quo + 1'b1;
          end else begin
            result <= (quo > lux_wide) ? quo : lux_wide;
            state  <= C_FIN;
          end
        end
        C_FIN: begin
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

/* sv/ambient_light_autorange_lux_correct.sv */
// Start items and samples that keep measuring or finish with raw lux give
// their registered result in the cycle after the transaction; samples that
// finish with corrected lux wait for the corrector (up to four passes of three
// 32x32 products on one multiplier, then up to six remainder corrections).
// Throughput: one at a time while correcting, else one a cycle unless stalled.
// Reset: synchronous; registers return to 1, 0, 100, 10000, steps to 1 and 0.
// ----------------------------------------------------------------------------
// ambient_light_autorange_lux_correct
// Gain and integration step auto-ranging controller for an ambient light
// sensor, with cubic lux correction through an iterative correction unit.
// ----------------------------------------------------------------------------
module ambient_light_autorange_lux_correct
  import alc_pkg::*;
#(
  parameter int LUX_FRAC_BITS = LUX_FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_wen,
  input  logic [IDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     kind,
  input  logic [CNT_W-1:0]         raw_count,
  input  logic [LUX_IN_W-1:0]      lux_in,
  // output channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [GAIN_W-1:0]        gain_code,
  output logic signed [TIME_W-1:0] time_code,
  output logic [ACT_W-1:0]         action,
  output logic [LUX_OUT_W-1:0]     lux_out
);

  typedef enum logic {
    ST_IDLE,
    ST_WAIT
  } top_state_t;

  top_state_t                state;
  logic [GAIN_W-1:0]         start_gain;
  logic signed [TIME_W-1:0]  start_time;
  logic [CNT_W-1:0]          low_limit;
  logic [CNT_W-1:0]          high_limit;
  logic [GAIN_W-1:0]         gain_step;
  logic signed [TIME_W-1:0]  time_step;

  logic                      accept;
  logic                      out_load;
  logic                      need_corr;
  logic [GAIN_W-1:0]         gain_next;
  logic signed [TIME_W-1:0]  time_next;
  logic [ACT_W-1:0]          act_next;
  logic [LUX_OUT_W-1:0]      lux_next;
  logic [GAIN_W-1:0]         gain_up;
  logic                      corr_done;
  logic [LUX_OUT_W-1:0]      corr_lux;

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;
  assign out_load = ((state == ST_IDLE) && accept && !need_corr) ||
                    ((state == ST_WAIT) && corr_done);

  // ranging decision for the incoming transaction
  always_comb begin
    gain_next = gain_step;
    time_next = time_step;
    act_next  = ACT_MEASURE;
    lux_next  = '0;
    need_corr = 1'b0;
    gain_up   = (gain_step < GAIN_MAX) ? gain_step + 1'b1 : gain_step;
    if (kind == KIND_START) begin
      if (start_gain < GAIN_MIN) begin
        gain_next = GAIN_MIN;
      end else if (start_gain > GAIN_MAX) begin
        gain_next = GAIN_MAX;
      end else begin
        gain_next = start_gain;
      end
      time_next = (start_time < TIME_MIN) ? TIME_MIN : start_time;
    end else if (raw_count <= low_limit) begin
      // dim: raise gain, then integration time
      gain_next = gain_up;
      if (gain_up == GAIN_MAX) begin
        if (time_step >= TIME_MAX) begin
          time_next = TIME_MAX;
          act_next  = ACT_RAW;
          lux_next  = {{(LUX_OUT_W-LUX_IN_W){1'b0}}, lux_in};
        end else begin
          time_next = time_step + 3'sd1;
        end
      end
    end else if (raw_count > high_limit) begin
      // bright: shorten integration, finish at the shortest step
      if (time_step <= TIME_MIN + 3'sd1) begin
        time_next = TIME_MIN;
        act_next  = ACT_CORR;
        need_corr = 1'b1;
      end else begin
        time_next = time_step - 3'sd1;
      end
    end else begin
      act_next  = ACT_CORR;
      need_corr = 1'b1;
    end
  end

  // cubic correction unit
  alc_corr #(
    .LUX_FRAC_BITS (LUX_FRAC_BITS)
  ) u_corr (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && need_corr),
    .lux    (lux_in),
    .done   (corr_done),
    .result (corr_lux)
  );

  // control state, registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      start_gain <= START_GAIN_RST;
      start_time <= START_TIME_RST;
      low_limit  <= LOW_LIMIT_RST;
      high_limit <= HIGH_LIMIT_RST;
      gain_step  <= GAIN_MIN;
      time_step  <= '0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_START_GAIN: start_gain <= cfg_data[GAIN_W-1:0];
          REG_START_TIME: start_time <= cfg_data[TIME_W-1:0];
          REG_LOW_LIMIT:  low_limit  <= cfg_data[CNT_W-1:0];
          REG_HIGH_LIMIT: high_limit <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      // output valid: a new result replaces a taken one
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            gain_step <= gain_next;
            time_step <= time_next;
            if (need_corr) begin
              state <= ST_WAIT;
            end else begin
              gain_code <= gain_next;
              time_code <= time_next;
              action    <= act_next;
              lux_out   <= lux_next;
            end
          end
        end
        ST_WAIT: begin
          if (corr_done) begin
            gain_code <= gain_step;
            time_code <= time_step;
            action    <= ACT_CORR;
            lux_out   <= corr_lux;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a correction only completes while the controller waits for it
  assert property (@(posedge clk) disable iff (rst) corr_done |-> state == ST_WAIT)
    else $error("correction finished outside of wait state");

  // ranging steps stay in their legal ranges
  assert property (@(posedge clk) disable iff (rst)
    (gain_step >= GAIN_MIN) && (gain_step <= GAIN_MAX) &&
    (time_step >= TIME_MIN) && (time_step <= TIME_MAX))
    else $error("ranging step out of range");

  // measure-again results carry zero lux
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == ACT_MEASURE) |-> lux_out == '0)
    else $error("non-zero lux on measure-again result");

  // a started correction keeps the input side stalled next cycle
  assert property (@(posedge clk) disable iff (rst)
    (accept && need_corr) |=> (state == ST_WAIT && in_stall))
    else $error("correction start did not block input");
`endif

endmodule

/* test/ambient_light_autorange_lux_correct_tb.sv */
// ----------------------------------------------------------------------------
// ambient_light_autorange_lux_correct_tb
// Drives start and sample transactions into the auto-ranging controller and
// checks every result against an in-bench model of the gain and integration
// stepping and of the cubic lux correction. Directed cases cover the step
// limits, clamped start values, crossed count limits and lux extremes, then
// random ranging sequences run under several register settings and idling
// patterns on both channels.
// ----------------------------------------------------------------------------
module ambient_light_autorange_lux_correct_tb;
  import alc_pkg::*;

  localparam int FRAC     = LUX_FRAC_BITS_DEF;
  localparam int SETTLE   = 64;
  localparam int GAIN_LO  = GAIN_MIN;
  localparam int GAIN_HI  = GAIN_MAX;
  localparam int TIME_LO  = TIME_MIN;
  localparam int TIME_HI  = TIME_MAX;
  localparam int MAX_SHOW = 10;

  typedef struct packed {
    logic [GAIN_W-1:0]        gain;
    logic signed [TIME_W-1:0] tstep;
    logic [ACT_W-1:0]         act;
    logic [LUX_OUT_W-1:0]     lux;
  } reading_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     cfg_wen;
  logic [IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     kind;
  logic [CNT_W-1:0]         raw_count;
  logic [LUX_IN_W-1:0]      lux_in;
  logic                     out_valid;
  logic                     out_stall;
  logic [GAIN_W-1:0]        gain_code;
  logic signed [TIME_W-1:0] time_code;
  logic [ACT_W-1:0]         action;
  logic [LUX_OUT_W-1:0]     lux_out;

  // model copy of the registers and the ranging steps
  logic [GAIN_W-1:0] load_gain    = START_GAIN_RST;
  logic [TIME_W-1:0] load_time    = START_TIME_RST;
  logic [CNT_W-1:0]  dim_limit    = LOW_LIMIT_RST;
  logic [CNT_W-1:0]  bright_limit = HIGH_LIMIT_RST;
  int                gain_now     = 1;
  int                itime_now    = 0;

  reading_t          expected_readings[$];
  logic [ACT_W-1:0]  last_action;
  int                mismatches    = 0;
  int                send_gap_pct  = 0;
  int                stall_pct     = 0;

  ambient_light_autorange_lux_correct #(
    .LUX_FRAC_BITS(FRAC)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .raw_count (raw_count),
    .lux_in    (lux_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gain_code (gain_code),
    .time_code (time_code),
    .action    (action),
    .lux_out   (lux_out)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < stall_pct);
  end

  // max of lux and the cubic fit, floored and saturated
  function automatic logic [LUX_OUT_W-1:0] cubic_lux(input logic [LUX_IN_W-1:0] x);
    logic [127:0] l, num, offs, q;
    l    = {96'd0, x};
    num  = l * l * l + ((l * l * 128'd3000) << FRAC)
         + ((l * 128'd1056400000) << (2 * FRAC));
    offs = 128'd30803000000 << (3 * FRAC);
    if (num <= offs) return {2'b00, x};
    q = ((num - offs) >> (2 * FRAC)) / 128'd1000000000;
    if (q > LUX_MAX) return LUX_MAX;
    if (q > l) return q[LUX_OUT_W-1:0];
    return {2'b00, x};
  endfunction

  // step the ranging state for one accepted transaction
  function automatic reading_t predict_ranging(input logic k, input logic [CNT_W-1:0] cnt,
                                               input logic [LUX_IN_W-1:0] lx);
    reading_t r;
    int       t;
    r.act = ACT_MEASURE;
    r.lux = '0;
    if (k == KIND_START) begin
      gain_now  = (load_gain < GAIN_LO) ? GAIN_LO :
                  ((load_gain > GAIN_HI) ? GAIN_HI : load_gain);
      t         = int'($signed(load_time));
      itime_now = (t < TIME_LO) ? TIME_LO : t;
    end else if (cnt <= dim_limit) begin
      if (gain_now < GAIN_HI) gain_now++;
      if (gain_now == GAIN_HI) begin
        if (itime_now >= TIME_HI) begin
          itime_now = TIME_HI;
          r.act     = ACT_RAW;
          r.lux     = {2'b00, lx};
        end else begin
          itime_now++;
        end
      end
    end else if (cnt > bright_limit) begin
      if (itime_now - 1 <= TIME_LO) begin
        itime_now = TIME_LO;
        r.act     = ACT_CORR;
        r.lux     = cubic_lux(lx);
      end else begin
        itime_now--;
      end
    end else begin
      r.act = ACT_CORR;
      r.lux = cubic_lux(lx);
    end
    r.gain  = gain_now[GAIN_W-1:0];
    r.tstep = itime_now[TIME_W-1:0];
    return r;
  endfunction

  // result checking
  always @(posedge clk) begin : check_readings
    reading_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOW)
          $display("unexpected transaction: gain %0d time %0d action %0d lux %0h",
                   gain_code, time_code, action, lux_out);
      end else begin
        want = expected_readings.pop_front();
        if (gain_code !== want.gain || time_code !== want.tstep ||
            action !== want.act || lux_out !== want.lux) begin
          mismatches++;
          if (mismatches <= MAX_SHOW)
            $display("mismatch: expected gain %0d time %0d action %0d lux %0h, got gain %0d time %0d action %0d lux %0h",
                     want.gain, want.tstep, want.act, want.lux,
                     gain_code, time_code, action, lux_out);
        end
      end
    end
  end

  // one transaction on the input channel
  task automatic send_reading(input logic k, input logic [CNT_W-1:0] c,
                              input logic [LUX_IN_W-1:0] l);
    reading_t want;
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    kind      = k;
    raw_count = c;
    lux_in    = l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want        = predict_ranging(k, c, l);
    last_action = want.act;
    expected_readings.push_back(want);
  endtask

  // hold the sender until every result is back
  task automatic wait_results_in(input int settle);
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_wen = 1'b0;
    case (idx)
      REG_START_GAIN: load_gain    = val[GAIN_W-1:0];
      REG_START_TIME: load_time    = val[TIME_W-1:0];
      REG_LOW_LIMIT:  dim_limit    = val;
      REG_HIGH_LIMIT: bright_limit = val;
      default: ;
    endcase
  endtask

  // all four registers, block idle
  task automatic write_setup(input logic [GAIN_W-1:0] g, input logic [TIME_W-1:0] t,
                             input logic [CNT_W-1:0] lo, input logic [CNT_W-1:0] hi);
    wait_results_in(SETTLE);
    write_reg(REG_START_GAIN, {{(CFG_W-GAIN_W){1'b0}}, g});
    write_reg(REG_START_TIME, {{(CFG_W-TIME_W){1'b0}}, t});
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_HIGH_LIMIT, hi);
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(4))
      0: return CNT_W'($urandom_range(0, dim_limit));
      1: return (bright_limit == 16'hFFFF) ? 16'hFFFF :
                CNT_W'($urandom_range(bright_limit + 1, 16'hFFFF));
      2: return (dim_limit < bright_limit) ?
                CNT_W'($urandom_range(dim_limit + 1, bright_limit)) : CNT_W'($urandom);
      default: return CNT_W'($urandom);
    endcase
  endfunction

  function automatic logic [LUX_IN_W-1:0] pick_lux();
    case ($urandom_range(6))
      0: return '0;
      1: return $urandom_range(0, 32'h003F_FFFF);
      2: return $urandom_range(32'h001F_0000, 32'h0025_0000);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 32'h00FF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // reset steps in force before any start transaction
  task automatic test_samples_after_reset();
    send_reading(KIND_SAMPLE, 16'd5000, 32'd0);
    send_reading(KIND_SAMPLE, dim_limit, 32'd12345);
    send_reading(KIND_SAMPLE, bright_limit + 16'd1, 32'h0010_0000);
    send_reading(KIND_SAMPLE, bright_limit, 32'hFFFF_FFFF);
  endtask

  // correction at small, threshold and large lux
  task automatic test_lux_extremes();
    send_reading(KIND_START, 16'd0, 32'd0);
    send_reading(KIND_SAMPLE, 16'd1000, 32'd4096);
    send_reading(KIND_SAMPLE, 16'd1000, 32'h0022_0000);
    send_reading(KIND_SAMPLE, 16'd1000, 32'h8000_0000);
  endtask

  // dim samples climb gain then time, finish on raw lux at the top
  task automatic test_dim_to_raw();
    int n;
    n = 0;
    send_reading(KIND_START, 16'hFFFF, 32'hFFFF_FFFF);
    do begin
      n++;
      send_reading(KIND_SAMPLE, n[0] ? dim_limit : 16'd0, 32'hFFFF_FFFF);
    end while (last_action == ACT_MEASURE);
  endtask

  // bright samples walk time down to its bottom
  task automatic test_bright_to_corrected();
    write_setup(3'd4, 3'd3, LOW_LIMIT_RST, HIGH_LIMIT_RST);
    send_reading(KIND_START, 16'd0, 32'd0);
    do begin
      send_reading(KIND_SAMPLE, 16'hFFFF, 32'h00AB_CDEF);
    end while (last_action == ACT_MEASURE);
  endtask

  // out-of-range start values are clamped on load
  task automatic test_start_clamps();
    write_setup(3'd0, 3'b100, LOW_LIMIT_RST, HIGH_LIMIT_RST);
    send_reading(KIND_START, 16'd0, 32'd0);
    send_reading(KIND_SAMPLE, 16'd20000, 32'd0);
    write_setup(3'd7, 3'b101, LOW_LIMIT_RST, HIGH_LIMIT_RST);
    send_reading(KIND_START, 16'd0, 32'd0);
    write_setup(3'd5, 3'b011, LOW_LIMIT_RST, HIGH_LIMIT_RST);
    send_reading(KIND_START, 16'd0, 32'd0);
  endtask

  // low limit above high limit, dim test takes priority
  task automatic test_crossed_limits();
    write_setup(3'd2, 3'd1, 16'd5000, 16'd1000);
    send_reading(KIND_SAMPLE, 16'd3000, 32'h0001_0000);
    send_reading(KIND_SAMPLE, 16'd6000, 32'h0001_0000);
  endtask

  // ranging sequences with random content, plus stray transactions
  task automatic run_sequences(input int n_items);
    int sent, steps;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(29) == 0) wait_results_in(0);
      if ($urandom_range(9) == 0) begin
        send_reading(1'($urandom_range(0, 1)), CNT_W'($urandom), $urandom);
        sent++;
      end else begin
        send_reading(KIND_START, CNT_W'($urandom), $urandom);
        sent++;
        steps = 0;
        do begin
          send_reading(KIND_SAMPLE, pick_count(), pick_lux());
          sent++;
          steps++;
        end while (last_action == ACT_MEASURE && steps < 12 && $urandom_range(15) != 0);
      end
    end
  endtask

  task automatic test_random_ranging();
    logic [CNT_W-1:0] lo, hi;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph < 3 ? ph : $urandom_range(3, 5))
        0: begin lo = 16'h0000; hi = 16'hFFFF; end
        1: begin lo = 16'hFFFF; hi = 16'h0000; end
        2: begin lo = LOW_LIMIT_RST; hi = HIGH_LIMIT_RST; end
        3: begin lo = CNT_W'($urandom); hi = CNT_W'($urandom); end
        default: begin
          lo = CNT_W'($urandom_range(0, 3000));
          hi = CNT_W'($urandom_range(4000, 65535));
        end
      endcase
      write_setup(GAIN_W'($urandom_range(0, 7)), TIME_W'($urandom_range(0, 7)), lo, hi);
      case (ph % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 83; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 83; end
        default: begin send_gap_pct = 21; stall_pct = 21; end
      endcase
      run_sequences(50);
    end
  endtask

  // stimulus
  initial begin
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_index = REG_START_GAIN;
    cfg_data  = '0;
    in_valid  = 1'b0;
    kind      = KIND_START;
    raw_count = '0;
    lux_in    = '0;
    out_stall = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_samples_after_reset();
    test_lux_extremes();
    test_dim_to_raw();
    test_bright_to_corrected();
    test_start_clamps();
    test_crossed_limits();
    test_random_ranging();

    wait_results_in(SETTLE);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* ambient_light_autorange_lux_correct.f */
sv/alc_pkg.sv
sv/alc_corr.sv
sv/ambient_light_autorange_lux_correct.sv
test/ambient_light_autorange_lux_correct_tb.sv
